/* src/lsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and codes of the led strip pattern generator.
// ----------------------------------------------------------------------------
package lsp_pkg;

   // operation codes of an input word
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // display modes
   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_FADE  = 2'd1;
   localparam logic [1:0] MODE_RANGE = 2'd2;
   localparam logic [1:0] MODE_TRI   = 2'd3;

   // access status codes
   localparam logic [1:0] ACC_OK          = 2'd0;
   localparam logic [1:0] ACC_BAD_VALUE   = 2'd1;
   localparam logic [1:0] ACC_BAD_ADDRESS = 2'd2;

   // csr register indexes
   localparam logic [1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_PIXEL_COUNT  = 2'd1;
   localparam logic [1:0] CSR_FADE_COLOR_A = 2'd2;
   localparam logic [1:0] CSR_FADE_COLOR_B = 2'd3;

   // fixed colors
   localparam logic [23:0] COLOR_BLACK  = 24'h000000;
   localparam logic [23:0] COLOR_RED    = 24'hFF0000;
   localparam logic [23:0] COLOR_YELLOW = 24'hFFFF00;
   localparam logic [23:0] COLOR_GREEN  = 24'h00FF00;

   // percent scale and its reciprocal, exact for values below 25600
   localparam logic [6:0]  PERCENT_FULL = 7'd100;
   localparam logic [12:0] RECIP_100    = 13'd5243;
   localparam int          RECIP_SHIFT  = 19;
   // reciprocal of three, exact for values below 128
   localparam logic [5:0]  RECIP_3      = 6'd43;
   localparam int          RECIP3_SHIFT = 7;

   typedef struct packed {
      logic [1:0]         operation;
      logic [15:0]        bus_address;
      logic signed [15:0] write_value;
   } req_word_type;

   typedef struct packed {
      logic [5:0]  pixel_index;
      logic [23:0] pixel_color;
      logic        last_pixel;
      logic [1:0]  access_status;
      logic [6:0]  read_data;
   } rsp_word_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_CALC,
      STATE_SCALE,
      STATE_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic calc;
      logic scale;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic frame_due;
      logic last_pix;
      logic out_free;
   } stat_type;

endpackage

/* src/led_strip_pattern_generator.sv */
`timescale 1ns / 1ps
// Register read or write: result in the next cycle; next word taken once output is free.
// Tick without frame: timers updated, no result.
// Frame tick: setup in CALC (blend products), then SCALE (scaling), then one pixel word
//   per cycle as the output register drains.
// Reset is synchronous, active high: control registers to defaults, mode off, timers cleared.
// ----------------------------------------------------------------------------
// led_strip_pattern_generator
// Led strip pattern generator: mode and level registers, frame output per frame tick.
// ----------------------------------------------------------------------------
module led_strip_pattern_generator
   import lsp_pkg::*;
#(
   parameter int MAX_PIXELS      = 64,
   parameter int FRAME_PERIOD_MS = 20,
   parameter int BLINK_PERIOD_MS = 500
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [23:0]  csr_data
);

   cmd_type  cmd;
   stat_type stat;

   // csr writes are always taken
   assign csr_ready = 1'b1;

   // sequencer
   lsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   lsp_datapath #(
      .MAX_PIXELS      (MAX_PIXELS),
      .FRAME_PERIOD_MS (FRAME_PERIOD_MS),
      .BLINK_PERIOD_MS (BLINK_PERIOD_MS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_word  (req_word),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

/* src/lsp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_ctrl
// Sequencer: takes input words, steps frame setup and pixel emission.
// ----------------------------------------------------------------------------
module lsp_ctrl
   import lsp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         STATE_IDLE: begin
            req_ready  = stat.out_free;
            cmd.accept = req_valid && stat.out_free;
            if (cmd.accept && stat.frame_due) begin
               state_in = STATE_CALC;
            end
         end
         STATE_CALC: begin
            cmd.calc = 1'b1;
            state_in = STATE_SCALE;
         end
         STATE_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = STATE_EMIT;
         end
         STATE_EMIT: begin
            cmd.emit = stat.out_free;
            if (stat.out_free && stat.last_pix) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // only one datapath command at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.calc, cmd.scale, cmd.emit}))
      else $error("more than one datapath command");

   // a frame setup always runs calc then scale
   a_calc_scale: assert property (@(posedge clock) disable iff (reset)
      cmd.calc |=> cmd.scale)
      else $error("scale did not follow calc");

   // input is never taken while a frame is being sent
   a_no_accept_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_EMIT) |-> !req_ready)
      else $error("input ready during frame emission");

endmodule

/* src/lsp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_datapath
// Registers, timers, fade blend, range and split math, pixel output register.
// ----------------------------------------------------------------------------
module lsp_datapath
   import lsp_pkg::*;
#(
   parameter int MAX_PIXELS      = 64,
   parameter int FRAME_PERIOD_MS = 20,
   parameter int BLINK_PERIOD_MS = 500
)
(
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output stat_type     stat,
   input  req_word_type req_word,
   input  logic         csr_valid,
   input  logic [1:0]   csr_index,
   input  logic [23:0]  csr_data,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   localparam int FT_W = $clog2(FRAME_PERIOD_MS + 1);
   localparam int BT_W = $clog2(BLINK_PERIOD_MS + 1);
   localparam logic [FT_W-1:0] FRAME_LAST = FT_W'(FRAME_PERIOD_MS);
   localparam logic [BT_W-1:0] BLINK_LAST = BT_W'(BLINK_PERIOD_MS);
   localparam logic [6:0]      COUNT_MAX  = 7'(MAX_PIXELS);

   // configuration
   logic [15:0] base_ff, base_in;
   logic [6:0]  count_cfg_ff, count_cfg_in;
   logic [23:0] color_a_ff, color_a_in;
   logic [23:0] color_b_ff, color_b_in;

   // pattern state
   logic [1:0]      mode_ff, mode_in;
   logic [6:0]      level_ff, level_in;
   logic [6:0]      progress_ff, progress_in;
   logic            fading_up_ff, fading_up_in;
   logic            blink_on_ff, blink_on_in;
   logic [FT_W-1:0] frame_timer_ff, frame_timer_in;
   logic [BT_W-1:0] blink_timer_ff, blink_timer_in;

   // frame setup pipeline
   logic [14:0] sum_ff [3];
   logic [14:0] sum_in [3];
   logic [13:0] range_prod_ff, range_prod_in;
   logic [5:0]  third_ff, third_in;
   logic [23:0] fill_ff, fill_in;
   logic [6:0]  lit_ff, lit_in;

   // pixel counter and output register
   logic [5:0]   idx_ff, idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic [6:0]      count_eff;
   logic [5:0]      count_last;
   logic [FT_W-1:0] ft_inc;
   logic [BT_W-1:0] bt_inc;
   logic [15:0]     raw;
   logic            is_mode_addr;
   logic            is_level_addr;
   logic            out_free;

   // effective pixel count, clamped to 1..MAX_PIXELS
   always_comb begin
      count_eff = count_cfg_ff;
      if (count_eff == 7'd0) begin
         count_eff = 7'd1;
      end
      if (count_eff > COUNT_MAX) begin
         count_eff = COUNT_MAX;
      end
   end
   assign count_last = 6'(count_eff - 7'd1);

   // saturating timer increments
   assign ft_inc = (frame_timer_ff < FRAME_LAST) ? frame_timer_ff + 1'b1 : frame_timer_ff;
   assign bt_inc = (blink_timer_ff < BLINK_LAST) ? blink_timer_ff + 1'b1 : blink_timer_ff;

   assign raw           = req_word.write_value;
   assign is_mode_addr  = (req_word.bus_address == base_ff);
   assign is_level_addr = (req_word.bus_address == base_ff + 16'd1);
   assign out_free      = !rsp_valid_ff || rsp_ready;

   assign stat.frame_due = (req_word.operation == OP_TICK) && (ft_inc >= FRAME_LAST);
   assign stat.last_pix  = (idx_ff == count_last);
   assign stat.out_free  = out_free;

   // configuration writes
   always_comb begin
      base_in      = base_ff;
      count_cfg_in = count_cfg_ff;
      color_a_in   = color_a_ff;
      color_b_in   = color_b_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BASE_ADDRESS: base_in      = csr_data[15:0];
            CSR_PIXEL_COUNT:  count_cfg_in = csr_data[6:0];
            CSR_FADE_COLOR_A: color_a_in   = csr_data;
            CSR_FADE_COLOR_B: color_b_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   // tick, register write and frame-start state updates
   always_comb begin
      mode_in        = mode_ff;
      level_in       = level_ff;
      progress_in    = progress_ff;
      fading_up_in   = fading_up_ff;
      blink_on_in    = blink_on_ff;
      frame_timer_in = frame_timer_ff;
      blink_timer_in = blink_timer_ff;
      if (cmd.accept) begin
         case (req_word.operation)
            OP_TICK: begin
               blink_timer_in = bt_inc;
               frame_timer_in = ft_inc;
               if (stat.frame_due) begin
                  frame_timer_in = '0;
                  case (mode_ff)
                     MODE_FADE: begin
                        if (fading_up_ff) begin
                           if (progress_ff >= PERCENT_FULL - 7'd1) begin
                              progress_in  = PERCENT_FULL;
                              fading_up_in = 1'b0;
                           end else begin
                              progress_in = progress_ff + 7'd1;
                           end
                        end else if (progress_ff <= 7'd1) begin
                           progress_in  = 7'd0;
                           fading_up_in = 1'b1;
                        end else begin
                           progress_in = progress_ff - 7'd1;
                        end
                     end
                     MODE_TRI: begin
                        if (bt_inc >= BLINK_LAST) begin
                           blink_on_in    = !blink_on_ff;
                           blink_timer_in = '0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            OP_WRITE: begin
               if (is_mode_addr) begin
                  if (raw <= 16'd3 && raw[1:0] != mode_ff) begin
                     mode_in        = raw[1:0];
                     progress_in    = 7'd0;
                     fading_up_in   = 1'b0;
                     blink_on_in    = 1'b1;
                     blink_timer_in = '0;
                     frame_timer_in = '0;
                  end
               end else if (is_level_addr) begin
                  if (raw <= 16'(PERCENT_FULL) && raw[6:0] != level_ff) begin
                     level_in       = raw[6:0];
                     frame_timer_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // frame setup: products, then scaling by the reciprocal of 100
   always_comb begin
      logic [6:0]  weight_a;
      logic [7:0]  chan_a;
      logic [7:0]  chan_b;
      logic [27:0] scaled;
      logic [26:0] lit_scaled;
      logic [12:0] third_prod;
      weight_a      = PERCENT_FULL - progress_ff;
      sum_in        = sum_ff;
      range_prod_in = range_prod_ff;
      third_in      = third_ff;
      fill_in       = fill_ff;
      lit_in        = lit_ff;
      for (int c = 0; c < 3; c++) begin
         chan_a = color_a_ff[8*c +: 8];
         chan_b = color_b_ff[8*c +: 8];
         if (cmd.calc) begin
            sum_in[c] = 15'(chan_a * weight_a) + 15'(chan_b * progress_ff);
         end
         scaled = sum_ff[c] * RECIP_100;
         if (cmd.scale) begin
            fill_in[8*c +: 8] = scaled[RECIP_SHIFT +: 8];
         end
      end
      third_prod = count_eff * RECIP_3;
      if (cmd.calc) begin
         range_prod_in = level_ff * count_eff;
         third_in      = third_prod[RECIP3_SHIFT +: 6];
      end
      lit_scaled = range_prod_ff * RECIP_100;
      if (cmd.scale) begin
         lit_in = lit_scaled[RECIP_SHIFT +: 7];
      end
   end

   // result words and pixel counter
   always_comb begin
      logic [23:0] color;
      logic [6:0]  pos;
      pos = {1'b0, idx_ff};
      color = COLOR_BLACK;
      case (mode_ff)
         MODE_FADE: color = fill_ff;
         MODE_RANGE: begin
            if (pos < lit_ff) begin
               color = COLOR_GREEN;
            end
         end
         MODE_TRI: begin
            if (blink_on_ff) begin
               if (idx_ff < third_ff) begin
                  color = COLOR_RED;
               end else if (pos < {third_ff, 1'b0}) begin
                  color = COLOR_YELLOW;
               end else begin
                  color = COLOR_GREEN;
               end
            end
         end
         default: color = COLOR_BLACK;
      endcase

      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      if (cmd.accept) begin
         idx_in = 6'd0;
         case (req_word.operation)
            OP_WRITE: begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '0;
               if (is_mode_addr) begin
                  rsp_word_in.access_status = (raw <= 16'd3) ? ACC_OK : ACC_BAD_VALUE;
               end else if (is_level_addr) begin
                  rsp_word_in.access_status =
                     (raw <= 16'(PERCENT_FULL)) ? ACC_OK : ACC_BAD_VALUE;
               end else begin
                  rsp_word_in.access_status = ACC_BAD_ADDRESS;
               end
            end
            OP_READ: begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '0;
               if (is_mode_addr) begin
                  rsp_word_in.read_data = {5'd0, mode_ff};
               end else if (is_level_addr) begin
                  rsp_word_in.read_data = level_ff;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.emit) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in               = '0;
         rsp_word_in.pixel_index   = idx_ff;
         rsp_word_in.pixel_color   = color;
         rsp_word_in.last_pixel    = stat.last_pix;
         idx_in                    = idx_ff + 6'd1;
      end
   end

   // control and pattern state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff        <= 16'd0;
         count_cfg_ff   <= 7'd1;
         color_a_ff     <= COLOR_BLACK;
         color_b_ff     <= COLOR_BLACK;
         mode_ff        <= MODE_OFF;
         level_ff       <= 7'd0;
         progress_ff    <= 7'd0;
         fading_up_ff   <= 1'b0;
         blink_on_ff    <= 1'b1;
         frame_timer_ff <= '0;
         blink_timer_ff <= '0;
         idx_ff         <= 6'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         base_ff        <= base_in;
         count_cfg_ff   <= count_cfg_in;
         color_a_ff     <= color_a_in;
         color_b_ff     <= color_b_in;
         mode_ff        <= mode_in;
         level_ff       <= level_in;
         progress_ff    <= progress_in;
         fading_up_ff   <= fading_up_in;
         blink_on_ff    <= blink_on_in;
         frame_timer_ff <= frame_timer_in;
         blink_timer_ff <= blink_timer_in;
         idx_ff         <= idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sum_ff        <= sum_in;
      range_prod_ff <= range_prod_in;
      third_ff      <= third_in;
      fill_ff       <= fill_in;
      lit_ff        <= lit_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // fade progress stays within 0..100
   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      progress_ff <= PERCENT_FULL)
      else $error("fade progress out of range");

   // level register only ever holds a validated value
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= PERCENT_FULL)
      else $error("range level out of range");

   // frame timer restarts on reaching the period
   a_frame_timer: assert property (@(posedge clock) disable iff (reset)
      frame_timer_ff < FRAME_LAST)
      else $error("frame timer reached the period");

   // a pixel is never sent beyond the strip
   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> ({1'b0, idx_ff} < count_eff))
      else $error("pixel index beyond strip length");

   // a new word never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept || cmd.emit) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

endmodule
